[design/tngr_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and codes of the two-nearest reachability unit
package tngr_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CRD_W      = 14;
	localparam int SQ_W       = 28;
	localparam int DIST_W     = SQ_W + 1;
	localparam int RC_W       = 11;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [CRD_W-1:0] crd_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_LOAD,
		ST_LDI,
		ST_CAPI,
		ST_SCAN,
		ST_D1,
		ST_D2,
		ST_WRN,
		ST_WINIT,
		ST_POP,
		ST_NB,
		ST_V1,
		ST_C1,
		ST_V2,
		ST_C2,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic store;
		logic start;
		logic rd_i;
		logic cap_i;
		logic scan;
		logic wr_nb;
		logic w_init;
		logic w_pop;
		logic w_nb;
		logic w_vis1;
		logic w_chk1;
		logic w_vis2;
		logic w_chk2;
		logic post;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic j_last;
		logic i_last;
		logic stack_empty;
		logic n_ge2;
		logic n_ge3;
		logic out_busy;
		logic pipe_busy;
	} sts_t;

endpackage

[design/tngr_pnt_if.sv]
`timescale 1ns / 1ps
// point channel: one word per point
interface tngr_pnt_if import tngr_pkg::*; ();
	logic valid;
	logic ready;
	crd_t coord_x;
	crd_t coord_y;
	logic last_point;

	modport source (output valid, output coord_x, output coord_y, output last_point,
		input ready);
	modport sink (input valid, input coord_x, input coord_y, input last_point,
		output ready);
endinterface

[design/tngr_res_if.sv]
`timescale 1ns / 1ps
// result channel: one word per point set
interface tngr_res_if import tngr_pkg::*; ();
	logic valid;
	logic ready;
	logic all_reachable;
	logic [RC_W-1:0] reached_count;

	modport source (output valid, output all_reachable, output reached_count, input ready);
	modport sink (input valid, input all_reachable, input reached_count, output ready);
endinterface

[design/tngr_datapath.sv]
`timescale 1ns / 1ps
// datapath: point store, neighbor search pipeline, neighbor tables and graph walk
module tngr_datapath import tngr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output sts_t            sts,
	input  crd_t            coord_x,
	input  crd_t            coord_y,
	output logic            res_valid,
	input  logic            res_ready,
	output logic            all_reachable,
	output logic [RC_W-1:0] reached_count
);

	function automatic logic beats(input logic [DIST_W-1:0] dc, input crd_t xc, input crd_t yc,
			input logic hok, input logic [DIST_W-1:0] dh, input crd_t xh, input crd_t yh);
		logic r;
		if (!hok) r = 1'b1;
		else if (dc != dh) r = dc < dh;
		else if (xc != xh) r = xc < xh;
		else r = yc < yh;
		return r;
	endfunction

	logic [2*CRD_W-1:0] xy_mem [MAX_POINTS];
	idx_t nb1_mem [MAX_POINTS];
	idx_t nb2_mem [MAX_POINTS];
	idx_t stk_mem [MAX_POINTS];
	logic vis_mem [MAX_POINTS];

	logic [2*CRD_W-1:0] xy_rd_q;
	cnt_t cnt_q;
	idx_t i_q, j_q, clr_q;
	crd_t xi_q, yi_q;

	logic v_s1, v_s2;
	idx_t j_s1, j_s2;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	crd_t x_s2, y_s2;

	logic ok1_q, ok2_q;
	idx_t c1_q, c2_q;
	logic [DIST_W-1:0] d1_q, d2_q;
	crd_t x1_q, y1_q, x2_q, y2_q;

	idx_t stk_rd_q, nb1_q, nb2_q;
	logic vis_q;
	cnt_t top_q, reached_q;
	logic res_valid_q, all_q;
	logic [RC_W-1:0] rc_q;

	logic store_we;
	idx_t xy_raddr;
	crd_t xj, yj;
	logic signed [CRD_W:0] dx, dy;
	logic signed [2*CRD_W+1:0] px, py;
	logic [DIST_W-1:0] cand_dist;
	logic b1, b2;
	logic room, push1, push2;
	idx_t vis_waddr, vis_raddr, stk_waddr;
	logic vis_we, vis_wd, stk_we;

	assign store_we = cmd.store && (cnt_q < CNT_W'(MAX_POINTS));
	assign xy_raddr = cmd.rd_i ? i_q : j_q;

	always_ff @(posedge clk) begin
		if (store_we) xy_mem[cnt_q[IDX_W-1:0]] <= {coord_x, coord_y};
		xy_rd_q <= xy_mem[xy_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.post) begin
			cnt_q <= '0;
		end else if (store_we) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.start) i_q <= '0;
			else if (cmd.wr_nb) i_q <= i_q + IDX_W'(1);
			if (cmd.cap_i) j_q <= '0;
			else if (cmd.scan) j_q <= j_q + IDX_W'(1);
			if (cmd.clr_step) clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_i) begin
			xi_q <= xy_rd_q[2*CRD_W-1:CRD_W];
			yi_q <= xy_rd_q[CRD_W-1:0];
		end
	end

	// stage 1: squared differences against the current point
	assign xj = xy_rd_q[2*CRD_W-1:CRD_W];
	assign yj = xy_rd_q[CRD_W-1:0];
	assign dx = {xj[CRD_W-1], xj} - {xi_q[CRD_W-1], xi_q};
	assign dy = {yj[CRD_W-1], yj} - {yi_q[CRD_W-1], yi_q};
	assign px = dx * dx;
	assign py = dy * dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan && (j_q != i_q);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		j_s1   <= j_q;
		j_s2   <= j_s1;
		sqx_s2 <= px[SQ_W-1:0];
		sqy_s2 <= py[SQ_W-1:0];
		x_s2   <= xj;
		y_s2   <= yj;
	end

	// stage 2: rank the candidate against the two held slots
	assign cand_dist = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign b1 = beats(cand_dist, x_s2, y_s2, ok1_q, d1_q, x1_q, y1_q);
	assign b2 = beats(cand_dist, x_s2, y_s2, ok2_q, d2_q, x2_q, y2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok1_q <= 1'b0;
			ok2_q <= 1'b0;
		end else if (cmd.cap_i) begin
			ok1_q <= 1'b0;
			ok2_q <= 1'b0;
		end else if (v_s2) begin
			if (b1) begin
				ok2_q <= ok1_q;
				ok1_q <= 1'b1;
			end else if (b2) begin
				ok2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_i) begin
			c1_q <= '0;
			c2_q <= '0;
		end else if (v_s2) begin
			if (b1) begin
				c2_q <= c1_q;
				d2_q <= d1_q;
				x2_q <= x1_q;
				y2_q <= y1_q;
				c1_q <= j_s2;
				d1_q <= cand_dist;
				x1_q <= x_s2;
				y1_q <= y_s2;
			end else if (b2) begin
				c2_q <= j_s2;
				d2_q <= cand_dist;
				x2_q <= x_s2;
				y2_q <= y_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_nb) begin
			nb1_mem[i_q] <= c1_q;
			nb2_mem[i_q] <= c2_q;
		end
		if (cmd.w_nb) begin
			nb1_q <= nb1_mem[stk_rd_q];
			nb2_q <= nb2_mem[stk_rd_q];
		end
	end

	// walk: stack and visited marks
	assign room  = top_q < CNT_W'(MAX_POINTS);
	assign push1 = cmd.w_chk1 && !vis_q && room;
	assign push2 = cmd.w_chk2 && !vis_q && room;

	always_comb begin
		vis_we    = 1'b0;
		vis_wd    = 1'b0;
		vis_waddr = clr_q;
		if (cmd.clr_step) begin
			vis_we = 1'b1;
		end else if (cmd.w_init) begin
			vis_we    = 1'b1;
			vis_wd    = 1'b1;
			vis_waddr = '0;
		end else if (push1) begin
			vis_we    = 1'b1;
			vis_wd    = 1'b1;
			vis_waddr = nb1_q;
		end else if (push2) begin
			vis_we    = 1'b1;
			vis_wd    = 1'b1;
			vis_waddr = nb2_q;
		end
	end

	assign vis_raddr = cmd.w_vis2 ? nb2_q : nb1_q;

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_waddr] <= vis_wd;
		if (cmd.w_vis1 || cmd.w_vis2) vis_q <= vis_mem[vis_raddr];
	end

	assign stk_we    = cmd.w_init || push1 || push2;
	assign stk_waddr = cmd.w_init ? '0 : top_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_waddr] <= cmd.w_init ? '0 : (push1 ? nb1_q : nb2_q);
		if (cmd.w_pop) stk_rd_q <= stk_mem[top_q[IDX_W-1:0] - IDX_W'(1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			reached_q <= '0;
		end else if (cmd.w_init) begin
			top_q     <= CNT_W'(1);
			reached_q <= CNT_W'(1);
		end else if (cmd.w_pop) begin
			top_q <= top_q - CNT_W'(1);
		end else if (push1 || push2) begin
			top_q     <= top_q + CNT_W'(1);
			reached_q <= reached_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.post) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			all_q <= reached_q == cnt_q;
			rc_q  <= RC_W'(reached_q);
		end
	end

	assign res_valid     = res_valid_q;
	assign all_reachable = all_q;
	assign reached_count = rc_q;

	assign sts.clr_last    = clr_q == IDX_W'(MAX_POINTS - 1);
	assign sts.j_last      = {1'b0, j_q} == (cnt_q - CNT_W'(1));
	assign sts.i_last      = {1'b0, i_q} == (cnt_q - CNT_W'(1));
	assign sts.stack_empty = top_q == '0;
	assign sts.n_ge2       = cnt_q >= CNT_W'(2);
	assign sts.n_ge3       = cnt_q >= CNT_W'(3);
	assign sts.out_busy    = res_valid_q;
	assign sts.pipe_busy   = v_s1 || v_s2;

endmodule

[design/tngr_ctrl.sv]
`timescale 1ns / 1ps
// controller: sequencing of load, neighbor search, walk and mark clearing
module tngr_ctrl import tngr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	output cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.store = 1'b1;
					if (in_last) begin
						cmd.start = 1'b1;
						state_nxt = ST_LDI;
					end
				end
			end
			ST_LDI: begin
				cmd.rd_i  = 1'b1;
				state_nxt = ST_CAPI;
			end
			ST_CAPI: begin
				cmd.cap_i = 1'b1;
				state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.j_last) state_nxt = ST_D1;
			end
			ST_D1: state_nxt = ST_D2;
			ST_D2: state_nxt = ST_WRN;
			ST_WRN: begin
				cmd.wr_nb = 1'b1;
				state_nxt = sts.i_last ? ST_WINIT : ST_LDI;
			end
			ST_WINIT: begin
				cmd.w_init = 1'b1;
				state_nxt  = ST_POP;
			end
			ST_POP: begin
				if (sts.stack_empty) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.w_pop = 1'b1;
					state_nxt = ST_NB;
				end
			end
			ST_NB: begin
				cmd.w_nb  = 1'b1;
				state_nxt = ST_V1;
			end
			ST_V1: begin
				if (sts.n_ge2) begin
					cmd.w_vis1 = 1'b1;
					state_nxt  = ST_C1;
				end else begin
					state_nxt = ST_POP;
				end
			end
			ST_C1: begin
				cmd.w_chk1 = 1'b1;
				state_nxt  = ST_V2;
			end
			ST_V2: begin
				if (sts.n_ge3) begin
					cmd.w_vis2 = 1'b1;
					state_nxt  = ST_C2;
				end else begin
					state_nxt = ST_POP;
				end
			end
			ST_C2: begin
				cmd.w_chk2 = 1'b1;
				state_nxt  = ST_POP;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.post  = 1'b1;
					state_nxt = ST_CLR;
				end
			end
			default: state_nxt = ST_CLR;
		endcase
	end

endmodule

[design/two_nearest_graph_reachability_unit.sv]
`timescale 1ns / 1ps
// top level of the two-nearest-neighbor graph reachability unit
//
// pnt carries one point word per cycle while the unit is loading (coord_x,
// coord_y, last_point); the word with last_point set closes the set. up to
// MAX_POINTS points are kept, further points are dropped but a dropped last
// word still closes the set. res carries one word per set: reached_count
// and all_reachable. after the last word, the neighbor search runs point by
// point, one pair a cycle through the point memory's single read port, then
// the walk follows. the result then stands in an output register; if the
// receiver stalls, the unit still clears its visited marks, loads and
// searches the next set, and waits for the result to be taken before it
// posts the next one. after every set and after reset the visited marks are
// swept clear, one entry a cycle over all MAX_POINTS (1024) entries, while
// pnt is not ready. reset is asynchronous and returns the unit to that
// sweep with no points.
module two_nearest_graph_reachability_unit import tngr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	tngr_pnt_if.sink   pnt,
	tngr_res_if.source res
);

	cmd_t cmd;
	sts_t sts;

	tngr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.in_valid (pnt.valid),
		.in_last  (pnt.last_point),
		.in_ready (pnt.ready),
		.cmd      (cmd)
	);

	tngr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.coord_x       (pnt.coord_x),
		.coord_y       (pnt.coord_y),
		.res_valid     (res.valid),
		.res_ready     (res.ready),
		.all_reachable (res.all_reachable),
		.reached_count (res.reached_count)
	);

	// point 0 always counts itself
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.reached_count != '0)
		else $error("result word with zero reached count");

	a_close_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		pnt.valid && pnt.ready && pnt.last_point |=> !pnt.ready)
		else $error("point channel still ready after closing word");

	a_load_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pnt.ready |-> !sts.pipe_busy)
		else $error("search pipeline busy while loading");

endmodule

[verif/tngr_reach_checker.sv]
`timescale 1ns / 1ps
// checker for the reachability unit: predicts each set's result and compares
module tngr_reach_checker import tngr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tngr_pnt_if  pnt,
	tngr_res_if  res,
	output int   errors,
	output int   pending
);

	typedef struct {
		logic             all_reached;
		logic [RC_W-1:0]  count;
	} reach_word_t;

	reach_word_t expected_reach[$];
	int set_x[MAX_POINTS];
	int set_y[MAX_POINTS];
	int set_size;

	// candidate c at distance dc beats holder h at distance dh
	function automatic bit closer(int c, longint dc, bit h_ok, int h, longint dh);
		if (!h_ok)
			return 1;
		if (dc != dh)
			return dc < dh;
		if (set_x[c] != set_x[h])
			return set_x[c] < set_x[h];
		return set_y[c] < set_y[h];
	endfunction

	function automatic reach_word_t predict_reach(int n);
		int near1[MAX_POINTS];
		int near2[MAX_POINTS];
		bit seen[MAX_POINTS];
		int walk[MAX_POINTS];
		int top;
		int reached;
		int u;
		int c1, c2;
		longint d1, d2, dd;
		bit ok1, ok2;
		reach_word_t r;
		for (int i = 0; i < n; i++) begin
			ok1 = 0; ok2 = 0; c1 = 0; c2 = 0; d1 = 64'd1 << 30; d2 = 64'd1 << 30;
			for (int j = 0; j < n; j++) begin
				if (i == j)
					continue;
				dd = longint'(set_x[i] - set_x[j]) * (set_x[i] - set_x[j])
					+ longint'(set_y[i] - set_y[j]) * (set_y[i] - set_y[j]);
				if (closer(j, dd, ok1, c1, d1)) begin
					ok2 = ok1; c2 = c1; d2 = d1;
					ok1 = 1; c1 = j; d1 = dd;
				end else if (closer(j, dd, ok2, c2, d2)) begin
					ok2 = 1; c2 = j; d2 = dd;
				end
			end
			near1[i] = c1;
			near2[i] = c2;
		end
		foreach (seen[k])
			seen[k] = 0;
		seen[0] = 1;
		reached = 1;
		walk[0] = 0;
		top = 1;
		while (top > 0) begin
			top = top - 1;
			u = walk[top];
			if (n >= 2 && !seen[near1[u]]) begin
				seen[near1[u]] = 1;
				reached++;
				walk[top] = near1[u];
				top = top + 1;
			end
			if (n >= 3 && !seen[near2[u]]) begin
				seen[near2[u]] = 1;
				reached++;
				walk[top] = near2[u];
				top = top + 1;
			end
		end
		r.all_reached = (reached == n);
		r.count = reached[RC_W-1:0];
		return r;
	endfunction

	assign pending = expected_reach.size();

	always @(posedge clk or negedge arst_n) begin
		reach_word_t e;
		if (!arst_n) begin
			set_size = 0;
			errors = 0;
			expected_reach.delete();
		end else begin
			if (pnt.valid && pnt.ready) begin
				if (set_size < MAX_POINTS) begin
					set_x[set_size] = int'(pnt.coord_x);
					set_y[set_size] = int'(pnt.coord_y);
					set_size++;
				end
				if (pnt.last_point) begin
					expected_reach = {expected_reach, predict_reach(set_size)};
					set_size = 0;
				end
			end
			if (res.valid && res.ready) begin
				if (expected_reach.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word: all_reachable=%0b reached_count=%0d",
							res.all_reachable, res.reached_count);
				end else begin
					e = expected_reach.pop_front();
					if (res.all_reachable !== e.all_reached || res.reached_count !== e.count) begin
						errors++;
						if (errors <= 10)
							$display("result mismatch: expected all_reachable=%0b reached_count=%0d, got %0b %0d",
								e.all_reached, e.count, res.all_reachable, res.reached_count);
					end
				end
			end
		end
	end

endmodule

[verif/two_nearest_graph_reachability_unit_tb.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the two-nearest-neighbor reachability unit
module two_nearest_graph_reachability_unit_tb;
	import tngr_pkg::*;

	localparam int STALL_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	bit   calm;
	int   errors;
	int   pending;
	int   points_sent;
	int   quiet_cycles;

	tngr_pnt_if pnt_ch ();
	tngr_res_if res_ch ();

	two_nearest_graph_reachability_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pnt    (pnt_ch),
		.res    (res_ch)
	);

	tngr_reach_checker reach_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.pnt     (pnt_ch),
		.res     (res_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		res_ch.ready <= 0;
		forever begin
			@(posedge clk);
			res_ch.ready <= calm || ($urandom_range(99) >= 8);
		end
	end

	// nothing moving on either channel for too long means the unit hung
	always @(posedge clk) begin
		if ((pnt_ch.valid && pnt_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_point(int x, int y, bit last);
		int gap;
		if (!calm && $urandom_range(99) < 8) begin
			gap = $urandom_range(1, 6);
			pnt_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pnt_ch.valid <= 1;
		pnt_ch.coord_x <= crd_t'(x);
		pnt_ch.coord_y <= crd_t'(y);
		pnt_ch.last_point <= last;
		do
			@(negedge clk);
		while (!pnt_ch.ready);
		@(posedge clk);
		points_sent++;
	endtask

	function automatic int pick_coord(int shape);
		case (shape)
			0: return $urandom_range(8) - 4;
			1: return $urandom_range(16383) - 8192;
			default: return ($urandom_range(1) ? 6000 : -6000) + $urandom_range(6) - 3;
		endcase
	endfunction

	task automatic send_random_set(int n);
		int shape;
		shape = $urandom_range(3);
		for (int i = 0; i < n; i++)
			send_point(pick_coord(shape), pick_coord(shape), i == n - 1);
	endtask

	initial begin
		pnt_ch.valid <= 0;
		pnt_ch.coord_x <= 0;
		pnt_ch.coord_y <= 0;
		pnt_ch.last_point <= 0;
		calm = 0;
		points_sent = 0;
		quiet_cycles = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// single point, then a pair
		send_point(0, 0, 1);
		send_point(8191, 8191, 0);
		send_point(-8192, -8192, 1);
		// equal distances: ties go to smaller x then smaller y
		send_point(0, 0, 0);
		send_point(1, 0, 0);
		send_point(-1, 0, 0);
		send_point(0, 1, 0);
		send_point(0, -1, 1);
		// extremes and duplicates, at three corners and at (5, 5)
		send_point(-8192, 8191, 0);
		send_point(8191, -8192, 0);
		send_point(8191, -8192, 0);
		send_point(-8192, 8191, 0);
		send_point(-8192, -8192, 0);
		send_point(5, 5, 0);
		send_point(5, 5, 0);
		send_point(5, 5, 1);
		// a chain where point 0 cannot reach the far pair
		send_point(0, 0, 0);
		send_point(1, 0, 0);
		send_point(2, 0, 0);
		send_point(1000, 0, 0);
		send_point(1001, 0, 1);

		// hold off until every result is back
		while (pending != 0) @(posedge clk);

		while (points_sent < 580) begin
			calm = (points_sent > 200 && points_sent < 320);
			if ($urandom_range(9) == 0)
				send_random_set($urandom_range(13, 40));
			else
				send_random_set($urandom_range(1, 12));
		end
		calm = 0;

		pnt_ch.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
